// ===== hw/rtl/pllfrw_pkg.sv =====
// shared types, constants and register word assembly for the pll register word unit
package pllfrw_pkg;

  localparam int unsigned WORD_COUNT = 14;

  // register number of the first word of a run
  localparam logic [3:0] FIRST_REG = 4'd13;
  localparam logic [3:0] LAST_REG  = 4'd0;

  // valid frequency window and divider breakpoints in MHz
  localparam logic [12:0] FREQ_LOW   = 13'd850;
  localparam logic [12:0] FREQ_HIGH  = 13'd6800;
  localparam logic [12:0] DIV4_BELOW = 13'd1700;
  localparam logic [12:0] DIV2_BELOW = 13'd3400;

  // output divider codes written into R6
  localparam logic [1:0] DIV_CODE_1 = 2'd0;
  localparam logic [1:0] DIV_CODE_2 = 2'd1;
  localparam logic [1:0] DIV_CODE_4 = 2'd2;

  // 1638400 = 25 * 2^16, so N * 2^24 = (f * div * 25) * 2^16 / 3
  localparam logic [4:0]  SCALE_ODD   = 5'd25;
  // divide by three: a = (q * RECIP_3) >> RECIP_SHIFT, exact for q < 2^19
  localparam logic [18:0] RECIP_3     = 19'd349526;
  localparam int unsigned RECIP_SHIFT = 20;
  // floor(r * 2^16 / 3) for remainders one and two
  localparam logic [15:0] THIRD_ONE   = 16'd21845;
  localparam logic [15:0] THIRD_TWO   = 16'd43690;

  localparam logic [31:0] R6_DIV_MASK  = 32'h00E0_0000;
  localparam logic [31:0] R0_INT_MASK  = 32'h000F_FFF0;
  localparam logic [31:0] R1_FRAC_MASK = 32'h0FFF_FFF0;

  // fixed register words, indexed by register number
  localparam logic [31:0] BASE_WORDS [WORD_COUNT] = '{
    32'h0030_0820, // R0
    32'h0355_5551, // R1
    32'h0000_0012, // R2
    32'h0000_0003, // R3
    32'h3201_0B84, // R4
    32'h0080_0025, // R5
    32'h3501_8466, // R6
    32'h0600_00E7, // R7
    32'h1559_6568, // R8
    32'h140D_3CC9, // R9
    32'h00C0_137A, // R10
    32'h0061_200B, // R11
    32'h0000_15FC, // R12
    32'h0000_000D  // R13
  };

  // per-request settings computed by the arithmetic pipeline
  typedef struct packed {
    logic [15:0] int_part;
    logic [23:0] frac_part;
    logic [1:0]  div_code;
    logic        range_bad;
  } pllfrw_calc_t;

  // assemble one register word from the request settings
  function automatic logic [31:0] make_word(input logic [3:0] reg_num,
                                            input pllfrw_calc_t c);
    logic [31:0] w;
    w = BASE_WORDS[reg_num];
    case (reg_num)
      4'd0:    w = (w & ~R0_INT_MASK) | {12'd0, c.int_part, 4'd0};
      4'd1:    w = (w & ~R1_FRAC_MASK) | {4'd0, c.frac_part, 4'd0};
      4'd6:    w = (w & ~R6_DIV_MASK) | {8'd0, 1'b0, c.div_code, 21'd0};
      default: w = w;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/pllfrw_calc.sv =====
// four-stage pipeline computing divider code and fixed-point integer/fraction of N
module pllfrw_calc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [12:0]            frequency_mhz,
  output logic                   res_valid,
  input  logic                   res_take,
  output pllfrw_pkg::pllfrw_calc_t res
);
  import pllfrw_pkg::*;

  // stage 1: divider select and range check
  logic        s1_valid;
  logic [12:0] s1_m;
  logic [1:0]  s1_code;
  logic        s1_bad;
  // stage 2: odd part of the scale factor
  logic        s2_valid;
  logic [17:0] s2_q;
  logic [1:0]  s2_code;
  logic        s2_bad;
  // stage 3: reciprocal product for the divide by three
  logic        s3_valid;
  logic [17:0] s3_q;
  logic [36:0] s3_prod;
  logic [1:0]  s3_code;
  logic        s3_bad;
  // stage 4: quotient, remainder fraction and final fields
  logic        s4_valid;
  pllfrw_calc_t s4_res;

  logic s1_ready, s2_ready, s3_ready, s4_ready;

  logic [12:0] m_next;
  logic [1:0]  code_next;
  logic [16:0] quot;
  logic [17:0] rem_full;
  logic [15:0] third_low;
  logic [32:0] scaled;

  // backpressure chain, a stage moves when the one after it frees up
  assign s4_ready = !s4_valid || res_take;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  assign res_valid = s4_valid;
  assign res       = s4_res;

  // divider choice, f times divider never exceeds 13 bits
  always_comb begin
    if (frequency_mhz < DIV4_BELOW) begin
      code_next = DIV_CODE_4;
      m_next    = {frequency_mhz[10:0], 2'b00};
    end else if (frequency_mhz < DIV2_BELOW) begin
      code_next = DIV_CODE_2;
      m_next    = {frequency_mhz[11:0], 1'b0};
    end else begin
      code_next = DIV_CODE_1;
      m_next    = frequency_mhz;
    end
  end

  // quotient and remainder of q by three, then P = a * 2^16 + floor(r * 2^16 / 3)
  always_comb begin
    quot     = s3_prod[RECIP_SHIFT +: 17];
    rem_full = s3_q - 18'(quot * 18'd3);
    case (rem_full[1:0])
      2'd1:    third_low = THIRD_ONE;
      2'd2:    third_low = THIRD_TWO;
      default: third_low = 16'd0;
    endcase
    scaled = {quot, third_low};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_m    <= m_next;
      s1_code <= code_next;
      s1_bad  <= (frequency_mhz < FREQ_LOW) || (frequency_mhz > FREQ_HIGH);
    end
    if (s2_ready && s1_valid) begin
      s2_q    <= 18'(s1_m * SCALE_ODD);
      s2_code <= s1_code;
      s2_bad  <= s1_bad;
    end
    if (s3_ready && s2_valid) begin
      s3_q    <= s2_q;
      s3_prod <= 37'(s2_q * RECIP_3);
      s3_code <= s2_code;
      s3_bad  <= s2_bad;
    end
    if (s4_ready && s3_valid) begin
      s4_res.int_part  <= {7'd0, scaled[32:24]};
      s4_res.frac_part <= scaled[23:0];
      s4_res.div_code  <= s3_code;
      s4_res.range_bad <= s3_bad;
    end
  end

endmodule

// ===== hw/rtl/pll_frequency_register_words_unit.sv =====
// top level: frequency request in, fourteen synthesizer register words out
//
// Input channel: one frequency_mhz per transfer (in_valid / in_stall).
// Output channel: one register word per transfer (out_valid / out_stall),
// register_number counts 13 down to 0, last_word marks register 0 and
// range_error is set on all fourteen words when the frequency is below 850
// or above 6800 MHz. Words are still computed for such frequencies.
// The first word of a request is shown once the request has passed the
// four-stage arithmetic pipeline and been loaded into the held settings.
// Throughput: one word per cycle while out_stall is low; the word sequencer
// starts the next request in the cycle after register 0 is taken, and up to
// four more requests wait in the pipeline meanwhile.
// When the receiver stalls the current word holds and the pipeline fills,
// then in_stall rises; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and the sequencer.
module pll_frequency_register_words_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] frequency_mhz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] register_word,
  output logic [3:0]  register_number,
  output logic        last_word,
  output logic        range_error
);
  import pllfrw_pkg::*;

  logic         calc_valid;
  logic         calc_take;
  pllfrw_calc_t calc_res;

  // sequencer registers
  logic         active;
  logic [3:0]   reg_num;
  pllfrw_calc_t held;

  logic         at_last;

  pllfrw_calc u_calc (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frequency_mhz(frequency_mhz),
    .res_valid    (calc_valid),
    .res_take     (calc_take),
    .res          (calc_res)
  );

  // a new request loads when idle or when register 0 leaves this cycle
  assign at_last   = (reg_num == LAST_REG);
  assign calc_take = calc_valid && (!active || (at_last && !out_stall));

  // word sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      reg_num <= FIRST_REG;
    end else if (calc_take) begin
      active  <= 1'b1;
      reg_num <= FIRST_REG;
    end else if (active && !out_stall) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        reg_num <= reg_num - 4'd1;
      end
    end
  end

  // request settings held for the whole run
  always_ff @(posedge clk) begin
    if (calc_take) begin
      held <= calc_res;
    end
  end

  // output word assembly from held settings
  assign out_valid       = active;
  assign register_number = reg_num;
  assign register_word   = make_word(reg_num, held);
  assign last_word       = at_last;
  assign range_error     = held.range_bad;

endmodule

// ===== hw/rtl/pllfrw_checker.sv =====
// port-level checker for the pll register word unit, bound to the top level
module pllfrw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] register_word,
  input logic [3:0]  register_number,
  input logic        last_word,
  input logic        range_error
);
  import pllfrw_pkg::*;

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(register_word)
      && $stable(register_number))
    else $error("stalled output word changed");

  // words of a run come in descending register order without gaps
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && register_number != LAST_REG |=>
      out_valid && register_number == $past(register_number) - 4'd1)
    else $error("register number did not count down");

  // last marks exactly register 0
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_word == (register_number == LAST_REG))
    else $error("last_word does not match register 0");

  // range flag is the same on every word of a run
  a_range_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && register_number != LAST_REG |=>
      range_error == $past(range_error))
    else $error("range_error changed within a run");

endmodule

bind pll_frequency_register_words_unit pllfrw_checker u_pllfrw_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .register_word  (register_word),
  .register_number(register_number),
  .last_word      (last_word),
  .range_error    (range_error)
);

// ===== tb/pll_frequency_register_words_unit_checker.sv =====
// checker for the pll register word unit: predicts the fourteen words per request and compares
module pll_frequency_register_words_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [12:0] frequency_mhz,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] register_word,
  input  logic [3:0]  register_number,
  input  logic        last_word,
  input  logic        range_error,
  output int          mismatch_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pllfrw_pkg::*;

  // registers that carry the per-request fields
  localparam logic [3:0] REG_INT  = 4'd0;
  localparam logic [3:0] REG_FRAC = 4'd1;
  localparam logic [3:0] REG_DIV  = 4'd6;

  // N * 2^24 = f * div * 1638400 / 3
  localparam logic [63:0] N_SCALE = 64'd1638400;
  localparam logic [63:0] N_DENOM = 64'd3;

  localparam int REPORT_LIMIT = 10;

  // power-on words, R13 in the top slot down to R0 in the bottom one
  localparam logic [13:0][31:0] FIXED_WORDS = {
    32'h0000_000D, // R13
    32'h0000_15FC, // R12
    32'h0061_200B, // R11
    32'h00C0_137A, // R10
    32'h140D_3CC9, // R9
    32'h1559_6568, // R8
    32'h0600_00E7, // R7
    32'h3501_8466, // R6
    32'h0080_0025, // R5
    32'h3201_0B84, // R4
    32'h0000_0003, // R3
    32'h0000_0012, // R2
    32'h0355_5551, // R1
    32'h0030_0820  // R0
  };

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  number;
    logic        last;
    logic        bad;
  } reg_word_t;

  reg_word_t expected_words [$];
  reg_word_t want;
  int        failures = 0;

  // work out the fourteen words for one frequency and queue them in output order
  task automatic queue_register_words(input logic [12:0] freq);
    logic [2:0]  divider;
    logic [1:0]  div_code;
    logic [63:0] scaled;
    logic [31:0] w;
    logic [3:0]  num;
    logic        bad;
    reg_word_t   item;
    int          k;
    if (freq < DIV4_BELOW) begin
      divider  = 3'd4;
      div_code = DIV_CODE_4;
    end else if (freq < DIV2_BELOW) begin
      divider  = 3'd2;
      div_code = DIV_CODE_2;
    end else begin
      divider  = 3'd1;
      div_code = DIV_CODE_1;
    end
    scaled = ({51'd0, freq} * {61'd0, divider} * N_SCALE) / N_DENOM;
    bad = (freq < FREQ_LOW) || (freq > FREQ_HIGH);
    for (k = 0; k < WORD_COUNT; k++) begin
      num = FIRST_REG - 4'(k);
      w = FIXED_WORDS[num];
      if (num == REG_INT) begin
        w[19:4] = scaled[39:24];
      end else if (num == REG_FRAC) begin
        w[27:4] = scaled[23:0];
      end else if (num == REG_DIV) begin
        w[23:21] = {1'b0, div_code};
      end
      item.word   = w;
      item.number = num;
      item.last   = (num == LAST_REG);
      item.bad    = bad;
      expected_words.push_back(item);
    end
  endtask

  // watch both channels: queue on each request transfer, compare on each word transfer
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      mismatch_count <= 0;
      words_pending  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_register_words(frequency_mhz);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("unexpected word %h reg %0d last %b err %b with nothing pending",
                     register_word, register_number, last_word, range_error);
          end
        end else begin
          want = expected_words.pop_front();
          if (register_word !== want.word || register_number !== want.number ||
              last_word !== want.last || range_error !== want.bad) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("word mismatch: got %h reg %0d last %b err %b, %s",
                       register_word, register_number, last_word, range_error,
                       $sformatf("want %h reg %0d last %b err %b",
                                 want.word, want.number, want.last, want.bad));
            end
          end
        end
      end
      mismatch_count <= failures;
      words_pending  <= expected_words.size();
    end
  end

endmodule

// ===== tb/pll_frequency_register_words_unit_test.sv =====
// testbench top for the pll register word unit: clock, reset, stimulus, stalls and verdict
module pll_frequency_register_words_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pllfrw_pkg::*;

  localparam int RANDOM_REQUESTS = 500;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CORNER_COUNT    = 20;

  // directed frequencies: field extremes, range and divider breakpoints, exact N values
  localparam logic [CORNER_COUNT-1:0][12:0] CORNER_FREQS = {
    13'd0,
    13'd1,
    FREQ_LOW - 13'd1,
    FREQ_LOW,
    FREQ_LOW + 13'd1,
    DIV4_BELOW - 13'd1,
    DIV4_BELOW,
    DIV2_BELOW - 13'd1,
    DIV2_BELOW,
    FREQ_HIGH,
    FREQ_HIGH + 13'd1,
    13'h1FFF,
    13'h0AAA,
    13'h1555,
    13'd1536,
    13'd3000,
    13'd6144,
    13'd1000,
    13'd5000,
    13'd7000
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [12:0] frequency_mhz = 13'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] register_word;
  logic [3:0]  register_number;
  logic        last_word;
  logic        range_error;

  int mismatch_count;
  int words_pending;
  int idle_cycles = 0;
  int stall_hold = 0;
  int burst_left = 0;

  pll_frequency_register_words_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .frequency_mhz   (frequency_mhz),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .register_word   (register_word),
    .register_number (register_number),
    .last_word       (last_word),
    .range_error     (range_error)
  );

  pll_frequency_register_words_unit_checker words_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .frequency_mhz   (frequency_mhz),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .register_word   (register_word),
    .register_number (register_number),
    .last_word       (last_word),
    .range_error     (range_error),
    .mismatch_count  (mismatch_count),
    .words_pending   (words_pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly in-range requests, some around the breakpoints, some anywhere in the field
  function automatic logic [12:0] pick_frequency();
    int          sel;
    logic [12:0] anchor;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return 13'($urandom_range(FREQ_LOW, FREQ_HIGH));
    end
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       anchor = FREQ_LOW;
        1:       anchor = DIV4_BELOW;
        2:       anchor = DIV2_BELOW;
        default: anchor = FREQ_HIGH;
      endcase
      return anchor + 13'($urandom_range(0, 6)) - 13'd3;
    end
    return 13'($urandom_range(0, 8191));
  endfunction

  // hold one request until its transfer, leave at the falling edge after it
  task automatic send_request(input logic [12:0] freq);
    in_valid <= 1'b1;
    frequency_mhz <= freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random sender gap: mostly none or short, a few long, with gap-free bursts
  task automatic pause_input();
    int r;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 60);
    end else begin
      r = $urandom_range(0, 99);
      if (r >= 90) begin
        gap = $urandom_range(8, 40);
      end else if (r >= 55) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      frequency_mhz <= 13'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall <= 1'b0;
          stall_hold <= $urandom_range(30, 150);
        end
        1, 2: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(10, 50);
        end
        3, 4, 5, 6, 7, 8: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(0, 3);
        end
        default: begin
          out_stall <= 1'b0;
          stall_hold <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pll_frequency_register_words_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, directed requests, random requests, drain and verdict
  initial begin
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (k = CORNER_COUNT - 1; k >= 0; k--) begin
      send_request(CORNER_FREQS[k]);
      pause_input();
    end

    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      send_request(pick_frequency());
      pause_input();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("pll_frequency_register_words_unit_test passed");
    end else begin
      $display("pll_frequency_register_words_unit_test failed");
    end
    $finish;
  end

endmodule
